FILE: rtl/core/tmba_pkg.sv
// Shared types, constants and the sensitivity decoder of the trimmed mean band alarm.
// Used by the window cells, the divider and the top level; depends on nothing else.
package tmba_pkg;

	localparam int VW             = 18;
	localparam int SUM_W          = 21;
	localparam int D_W            = 3;
	localparam int N_W            = 4;
	localparam int TRIG_W         = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int WINDOW_DEPTH_DEF = 8;

	localparam logic [VW:0]   WIDEN_HIGH = 19'd2621;
	localparam logic [VW:0]   WIDEN_LOW  = 19'd1311;
	localparam logic [VW-1:0] SHORT_HIGH = 18'd1311;
	localparam logic [VW-1:0] SHORT_LOW  = 18'd131;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENS   = 3'd0,
		CFG_LEVEL  = 3'd1,
		CFG_TOUCH  = 3'd2,
		CFG_HBMAX  = 3'd3,
		CFG_HBMIN  = 3'd4,
		CFG_LBMAX  = 3'd5,
		CFG_LBMIN  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [VW-1:0]    hi;
		logic [VW-1:0]    lo;
	} scan_t;

	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [TRIG_W-1:0] trig;
		logic [D_W-1:0]    d;
	} sens_cfg_t;

	function automatic sens_cfg_t sens_decode(input logic [1:0] sens);
		sens_cfg_t r;
		unique case (sens)
			2'd2: begin
				r.n = 4'd5; r.trig = 2'd2; r.d = 3'd3;
			end
			2'd1: begin
				r.n = 4'd8; r.trig = 2'd2; r.d = 3'd6;
			end
			default: begin
				r.n = 4'd3; r.trig = 2'd1; r.d = 3'd1;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/tmba_cell.sv
// One window cell: holds one entry of the high and of the low window and one
// stage of the running sum, maximum and minimum. Depends on tmba_pkg.
module tmba_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic                  level_sel,
	input  logic                  active,
	input  logic [tmba_pkg::VW-1:0] shift_din,
	output logic [tmba_pkg::VW-1:0] shift_dout,
	input  tmba_pkg::scan_t       scan_in,
	output tmba_pkg::scan_t       scan_out
);
	import tmba_pkg::*;

	logic [VW-1:0] entry_q [2];
	logic [VW-1:0] e;
	scan_t         scan_d;
	scan_t         scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q[0] <= '0;
			entry_q[1] <= '0;
		end else if (shift_en && active) begin
			entry_q[level_sel] <= shift_din;
		end
	end

	assign e          = entry_q[level_sel];
	assign shift_dout = e;

	always_comb begin
		scan_d = scan_in;
		if (active) begin
			scan_d.sum = scan_in.sum + SUM_W'(e);
			if (e > scan_in.hi) scan_d.hi = e;
			if (e < scan_in.lo) scan_d.lo = e;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
	end

	assign scan_out = scan_q;

endmodule

FILE: rtl/core/tmba_divider.sv
// Reciprocal-multiply divider for the trimmed mean: divides by one, three or six.
// Depends on tmba_pkg for the dividend and divisor widths.
module tmba_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tmba_pkg::SUM_W-1:0] dividend,
	input  logic [tmba_pkg::D_W-1:0]   divisor,
	output logic [tmba_pkg::SUM_W-1:0] quotient,
	output logic                       done
);
	import tmba_pkg::*;

	localparam int MUL_W     = 2 * SUM_W;
	localparam int RECIP3_SH = SUM_W + 1;
	localparam logic [SUM_W-1:0] RECIP3 = SUM_W'(((64'd1 << RECIP3_SH) + 64'd2) / 64'd3);

	logic             busy_q;
	logic             done_q;
	logic [SUM_W-1:0] dvd_q;
	logic [D_W-1:0]   dsr_q;
	logic [SUM_W-1:0] quo_q;
	logic [MUL_W-1:0] prod;
	logic [SUM_W-1:0] third;
	logic [SUM_W-1:0] quo_d;

	// A divisor of six is a third halved.
	assign prod  = MUL_W'(dvd_q) * MUL_W'(RECIP3);
	assign third = SUM_W'(prod >> RECIP3_SH);

	always_comb begin
		if (dsr_q == D_W'(1)) quo_d = dvd_q;
		else if (dsr_q == D_W'(3)) quo_d = third;
		else quo_d = third >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
		end
		if (busy_q) quo_q <= quo_d;
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

FILE: rtl/core/trimmed_mean_band_alarm.sv
// Trimmed mean band alarm: a row of window cells, a reciprocal-multiply divider and the alarm logic.
// A beat passes the shift, scan, load, divide and finish states before its result beat is valid.
// One item at a time: a new beat is taken only once the previous one has left the finish state,
// after the pass of the sum down the cell row; a result beat left waiting holds the next one back.
// Reset clears the configuration registers, both windows, fill counts and alarm state.
module trimmed_mean_band_alarm #(
	parameter int WINDOW_DEPTH = tmba_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tmba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmba_pkg::VW-1:0]        cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tmba_pkg::VW-1:0]        peak_voltage,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tmba_pkg::VW-1:0]        filtered_voltage,
	output logic                           touch_alarm,
	output logic                           short_masked,
	output logic                           filter_ready
);
	import tmba_pkg::*;

	localparam int SC_W = $clog2(WINDOW_DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SHIFT  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_LOAD   = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t          state_q;
	logic [1:0]      sens_q;
	logic            level_q;
	logic            touch_en_q;
	logic [VW-1:0]   hbmax_q, hbmin_q, lbmax_q, lbmin_q;
	logic [VW-1:0]   sample_q;
	logic [N_W-1:0]  fill_q [2];
	logic [1:0]      ready_q;
	logic [TRIG_W-1:0] touch_cnt_q;
	logic            alarm_q;
	logic            short_q;
	logic [SC_W-1:0] scan_cnt_q;
	logic            out_valid_q;
	logic [VW-1:0]   out_v_q;
	logic            out_alarm_q, out_short_q, out_ready_flag_q;

	sens_cfg_t       dec;
	logic [VW-1:0]   shift_link [WINDOW_DEPTH+1];
	scan_t           scan_link [WINDOW_DEPTH+1];
	logic [WINDOW_DEPTH-1:0] cell_active;
	logic            shift_en;

	logic            div_start;
	logic            div_done;
	logic [SUM_W-1:0] dividend;
	logic [SUM_W-1:0] quotient;

	logic            out_free;
	logic [N_W-1:0]  fill_next;
	logic            lvl_ready;
	logic [VW-1:0]   v;
	logic [VW-1:0]   bmax, bmin, short_thr;
	logic [VW:0]     widen, upper;
	logic            above, below, touch;
	logic [TRIG_W-1:0] cnt_inc;

	assign dec = sens_decode(sens_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q     <= 2'd3;
			level_q    <= 1'b0;
			touch_en_q <= 1'b0;
			hbmax_q    <= '0;
			hbmin_q    <= '0;
			lbmax_q    <= '0;
			lbmin_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SENS:  sens_q     <= cfg_wdata[1:0];
				CFG_LEVEL: level_q    <= cfg_wdata[0];
				CFG_TOUCH: touch_en_q <= cfg_wdata[0];
				CFG_HBMAX: hbmax_q    <= cfg_wdata;
				CFG_HBMIN: hbmin_q    <= cfg_wdata;
				CFG_LBMAX: lbmax_q    <= cfg_wdata;
				CFG_LBMIN: lbmin_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign shift_en      = (state_q == ST_SHIFT);
	assign shift_link[0] = sample_q;
	assign scan_link[0]  = '{sum: '0, hi: '0, lo: '1};

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		assign cell_active[i] = (N_W'(i) < dec.n);
		tmba_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (shift_en),
			.level_sel  (level_q),
			.active     (cell_active[i]),
			.shift_din  (shift_link[i]),
			.shift_dout (shift_link[i+1]),
			.scan_in    (scan_link[i]),
			.scan_out   (scan_link[i+1])
		);
	end

	assign div_start = (state_q == ST_LOAD);
	assign dividend  = scan_link[WINDOW_DEPTH].sum
	                 - SUM_W'(scan_link[WINDOW_DEPTH].hi)
	                 - SUM_W'(scan_link[WINDOW_DEPTH].lo)
	                 + SUM_W'(dec.d >> 1);

	tmba_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (dec.d),
		.quotient (quotient),
		.done     (div_done)
	);

	assign fill_next = fill_q[level_q] + 1'b1;
	assign lvl_ready = ready_q[level_q];
	assign v         = lvl_ready ? quotient[VW-1:0] : sample_q;
	assign bmax      = level_q ? lbmax_q : hbmax_q;
	assign bmin      = level_q ? lbmin_q : hbmin_q;
	assign widen     = level_q ? WIDEN_LOW : WIDEN_HIGH;
	assign short_thr = level_q ? SHORT_LOW : SHORT_HIGH;
	assign upper     = {1'b0, bmax} + widen;
	assign above     = {1'b0, v} > upper;
	assign below     = ({1'b0, v} + widen) < {1'b0, bmin};
	assign touch     = touch_en_q && lvl_ready && (v > short_thr) && (above || below);
	assign cnt_inc   = touch_cnt_q + 1'b1;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			ready_q     <= '0;
			touch_cnt_q <= '0;
			alarm_q     <= 1'b0;
			short_q     <= 1'b0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (!lvl_ready) begin
						fill_q[level_q] <= fill_next;
						if (fill_next >= dec.n) ready_q[level_q] <= 1'b1;
					end
					scan_cnt_q <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == SC_W'(WINDOW_DEPTH - 1)) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						if (touch) begin
							if (cnt_inc >= dec.trig) begin
								touch_cnt_q <= '0;
								alarm_q     <= 1'b1;
								short_q     <= 1'b1;
							end else begin
								touch_cnt_q <= cnt_inc;
							end
						end else begin
							short_q     <= !(v < short_thr);
							alarm_q     <= 1'b0;
							touch_cnt_q <= '0;
						end
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) sample_q <= peak_voltage;
		if (state_q == ST_FINISH && out_free) begin
			out_v_q          <= v;
			out_alarm_q      <= touch ? (alarm_q || cnt_inc >= dec.trig) : 1'b0;
			out_short_q      <= touch ? (short_q || cnt_inc >= dec.trig) : !(v < short_thr);
			out_ready_flag_q <= lvl_ready;
		end
	end

	assign out_valid        = out_valid_q;
	assign filtered_voltage = out_v_q;
	assign touch_alarm      = out_alarm_q;
	assign short_masked     = out_short_q;
	assign filter_ready     = out_ready_flag_q;

`ifndef NO_ASSERTIONS
	// The touch alarm is only ever raised together with the short mask.
	a_alarm_needs_short: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_q |-> short_q) else $error("alarm set without short mask");

	// A level whose window has filled stays ready.
	a_high_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q[0] |=> ready_q[0]) else $error("high level lost readiness");

	a_low_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q[1] |=> ready_q[1]) else $error("low level lost readiness");

	// The stored touch count never reaches two: the trigger clears it first.
	a_touch_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(touch_cnt_q == 2'd0) || (touch_cnt_q == 2'd1)) else $error("touch count overran");

	// The divider finishes only while the sequencer is waiting for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVIDE)) else $error("divider finished out of turn");
`endif

endmodule

FILE: verif/tb_trimmed_mean_band_alarm.sv
// Testbench for trimmed_mean_band_alarm: sends sample beats with random gaps and back-pressure,
// predicts every result beat from its own copy of the windows and alarm state, and checks it.
// Depends on tmba_pkg and the trimmed_mean_band_alarm top level.
module tb_trimmed_mean_band_alarm;
	import tmba_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int CALM_ITEMS   = 150;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_REPORTS  = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [VW-1:0] V_MAX = '1;
	localparam logic LEVEL_HIGH = 1'b0;

	typedef struct packed {
		logic [VW-1:0] voltage;
		logic          alarm;
		logic          masked;
		logic          ready;
	} alarm_beat_t;

	class band_alarm_checker;
		logic [1:0]    sens;
		logic          level;
		logic          touch_en;
		logic [VW-1:0] band_max [2];
		logic [VW-1:0] band_min [2];
		logic [VW-1:0] win [2][WINDOW_DEPTH_DEF];
		logic [3:0]    fill [2];
		logic          rdy [2];
		logic [1:0]    touch_cnt;
		logic          alarm;
		logic          masked;
		alarm_beat_t   predicted [$];
		int            mismatches;
		int            checked;
		int            alarms_seen;

		function new();
			sens = 2'd3;
			level = LEVEL_HIGH;
			touch_en = 1'b0;
			for (int l = 0; l < 2; l++) begin
				band_max[l] = '0;
				band_min[l] = '0;
				fill[l] = '0;
				rdy[l] = 1'b0;
				for (int i = 0; i < WINDOW_DEPTH_DEF; i++)
					win[l][i] = '0;
			end
			touch_cnt = '0;
			alarm = 1'b0;
			masked = 1'b0;
			mismatches = 0;
			checked = 0;
			alarms_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
			case (idx)
				CFG_SENS:  sens = data[1:0];
				CFG_LEVEL: level = data[0];
				CFG_TOUCH: touch_en = data[0];
				CFG_HBMAX: band_max[0] = data;
				CFG_HBMIN: band_min[0] = data;
				CFG_LBMAX: band_max[1] = data;
				CFG_LBMIN: band_min[1] = data;
				default: ;
			endcase
		endfunction

		function alarm_beat_t filter_and_decide(logic [VW-1:0] sample);
			int               n;
			int               trig;
			int               d;
			int               upper;
			int               lower;
			int               shortv;
			int               sv;
			logic [SUM_W-1:0] sum;
			logic [VW-1:0]    hi;
			logic [VW-1:0]    lo;
			logic [VW-1:0]    v;
			alarm_beat_t      r;
			case (sens)
				2'd2: begin
					n = 5; trig = 2;
				end
				2'd1: begin
					n = 8; trig = 2;
				end
				default: begin
					n = 3; trig = 1;
				end
			endcase
			for (int i = n - 1; i >= 1; i--)
				win[level][i] = win[level][i-1];
			win[level][0] = sample;
			if (!rdy[level]) begin
				fill[level] = fill[level] + 4'd1;
				if (int'(fill[level]) >= n)
					rdy[level] = 1'b1;
			end
			if (rdy[level]) begin
				sum = '0;
				hi = win[level][0];
				lo = win[level][0];
				for (int i = 0; i < n; i++) begin
					sum = sum + win[level][i];
					if (win[level][i] > hi) hi = win[level][i];
					if (win[level][i] < lo) lo = win[level][i];
				end
				sum = sum - hi - lo;
				d = n - 2;
				v = VW'((int'(sum) + d / 2) / d);
			end else begin
				v = sample;
			end
			if (level == LEVEL_HIGH) begin
				upper = int'(band_max[0]) + int'(WIDEN_HIGH);
				lower = int'(band_min[0]) - int'(WIDEN_HIGH);
				shortv = int'(SHORT_HIGH);
			end else begin
				upper = int'(band_max[1]) + int'(WIDEN_LOW);
				lower = int'(band_min[1]) - int'(WIDEN_LOW);
				shortv = int'(SHORT_LOW);
			end
			sv = int'(v);
			if (touch_en && rdy[level] && sv > shortv && (sv > upper || sv < lower)) begin
				touch_cnt = touch_cnt + 2'd1;
				if (int'(touch_cnt) >= trig) begin
					touch_cnt = '0;
					alarm = 1'b1;
					masked = 1'b1;
				end
			end else if (sv < shortv) begin
				masked = 1'b0;
				alarm = 1'b0;
				touch_cnt = '0;
			end else begin
				masked = 1'b1;
				alarm = 1'b0;
				touch_cnt = '0;
			end
			r.voltage = v;
			r.alarm = alarm;
			r.masked = masked;
			r.ready = rdy[level];
			return r;
		endfunction

		function void note_sample(logic [VW-1:0] sample);
			predicted.push_back(filter_and_decide(sample));
		endfunction

		function int pending();
			return predicted.size();
		endfunction

		task report(string what, int got, int want);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch at result %0d: %s got %0d, expected %0d", checked, what, got, want);
		endtask

		task check_beat(alarm_beat_t got);
			alarm_beat_t want;
			if (predicted.size() == 0) begin
				report("result beat with nothing outstanding, voltage", got.voltage, 0);
			end else begin
				want = predicted.pop_front();
				if (got.voltage !== want.voltage) report("filtered_voltage", got.voltage, want.voltage);
				if (got.alarm !== want.alarm) report("touch_alarm", got.alarm, want.alarm);
				if (got.masked !== want.masked) report("short_masked", got.masked, want.masked);
				if (got.ready !== want.ready) report("filter_ready", got.ready, want.ready);
			end
			checked++;
			if (got.alarm === 1'b1)
				alarms_seen++;
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VW-1:0]        cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [VW-1:0]        peak_voltage = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [VW-1:0]        filtered_voltage;
	logic                 touch_alarm;
	logic                 short_masked;
	logic                 filter_ready;

	band_alarm_checker chk = new();
	int sent = 0;
	int settings_used = 0;
	bit calm = 1'b0;
	int send_gap_pct = 20;
	int stall_pct = 5;
	int cycle_count = 0;

	trimmed_mean_band_alarm u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.peak_voltage     (peak_voltage),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.filtered_voltage (filtered_voltage),
		.touch_alarm      (touch_alarm),
		.short_masked     (short_masked),
		.filter_ready     (filter_ready)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			chk.check_beat({filtered_voltage, touch_alarm, short_masked, filter_ready});
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped at the cycle limit with %0d results outstanding", chk.pending());
		$display("** trimmed_mean_band_alarm: FAILED **");
		$finish;
	end

	task automatic wait_drained();
		if (chk.pending() != 0) begin
			in_valid <= 1'b0;
			while (chk.pending() != 0) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		chk.set_reg(idx, data);
	endtask

	// Narrow registers get random upper bits, which the block must ignore.
	task automatic apply_settings(logic [1:0] sens, logic level, logic en,
			logic [VW-1:0] hmax, logic [VW-1:0] hmin, logic [VW-1:0] lmax, logic [VW-1:0] lmin);
		wait_drained();
		write_reg(CFG_SENS, (VW'($urandom) & ~VW'(3)) | VW'(sens));
		write_reg(CFG_LEVEL, (VW'($urandom) & ~VW'(1)) | VW'(level));
		write_reg(CFG_TOUCH, (VW'($urandom) & ~VW'(1)) | VW'(en));
		write_reg(CFG_HBMAX, hmax);
		write_reg(CFG_HBMIN, hmin);
		write_reg(CFG_LBMAX, lmax);
		write_reg(CFG_LBMIN, lmin);
		write_reg(CFG_UNUSED, VW'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_sample(logic [VW-1:0] v);
		if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		peak_voltage <= v;
		do @(posedge clk); while (!in_ready);
		chk.note_sample(v);
		sent++;
	endtask

	function automatic void pick_band(output logic [VW-1:0] bmax, output logic [VW-1:0] bmin);
		int r;
		int lo;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			bmax = V_MAX;
			bmin = '0;
		end else if (r == 1) begin
			bmax = VW'($urandom);
			bmin = VW'($urandom);
		end else if (r == 2) begin
			bmax = V_MAX;
			bmin = V_MAX;
		end else begin
			lo = $urandom_range(0, 150000);
			bmin = VW'(lo);
			bmax = VW'(lo + $urandom_range(0, 40000));
		end
	endfunction

	// A sample class: anything, anything up to just over short level, inside the band, just over either edge,
	// the extremes, or anywhere above the widened band.
	function automatic logic [VW-1:0] pick_sample(int kind);
		int shortv;
		int up;
		int lo;
		int x;
		int l;
		l = chk.level;
		shortv = (chk.level == LEVEL_HIGH) ? int'(SHORT_HIGH) : int'(SHORT_LOW);
		up = int'(chk.band_max[l]) + ((chk.level == LEVEL_HIGH) ? int'(WIDEN_HIGH) : int'(WIDEN_LOW));
		lo = int'(chk.band_min[l]) - ((chk.level == LEVEL_HIGH) ? int'(WIDEN_HIGH) : int'(WIDEN_LOW));
		case (kind)
			0: x = $urandom_range(0, int'(V_MAX));
			1: x = $urandom_range(0, shortv + 1);
			2: x = (chk.band_min[l] <= chk.band_max[l]) ?
				$urandom_range(int'(chk.band_min[l]), int'(chk.band_max[l])) : int'(chk.band_min[l]);
			3: x = up - 2 + $urandom_range(0, 40);
			4: x = lo + 2 - $urandom_range(0, 40);
			5: x = $urandom_range(0, 1) ? int'(V_MAX) : 0;
			default: x = (up < int'(V_MAX)) ? $urandom_range(up, int'(V_MAX)) : int'(V_MAX);
		endcase
		if (x < 0) x = 0;
		if (x > int'(V_MAX)) x = int'(V_MAX);
		return VW'(x);
	endfunction

	initial begin
		logic [VW-1:0] hmax;
		logic [VW-1:0] hmin;
		logic [VW-1:0] lmax;
		logic [VW-1:0] lmin;
		int items;
		int kind;
		int run;
		int r;
		int pct_sel;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: high level, window 3, touch detection off.
		send_sample('0);
		send_sample(V_MAX);
		send_sample(SHORT_HIGH);
		send_sample(SHORT_HIGH - 18'd1);

		// The low window starts filling at length 8 and becomes ready once the length drops to 3.
		apply_settings(2'd1, 1'b1, 1'b1, '0, '0, V_MAX, '0);
		send_sample(18'd5000);
		send_sample(18'd6000);
		send_sample(18'd7000);
		apply_settings(2'd0, 1'b1, 1'b1, '0, '0, V_MAX, '0);
		send_sample(18'd8000);
		send_sample(SHORT_LOW);
		send_sample(SHORT_LOW - 18'd1);
		send_sample(SHORT_LOW + 18'd1);

		apply_settings(2'd2, 1'b0, 1'b1, 18'd20000, 18'd10000, V_MAX, '0);
		send_sample(18'd30000);
		send_sample(18'd30000);
		send_sample(18'd5000);
		send_sample(18'd5000);
		send_sample(18'd100);
		send_sample(18'd100);

		apply_settings(2'd1, 1'b1, 1'b1, 18'd20000, 18'd10000, 18'd5000, 18'd4000);
		send_sample(18'd9000);
		send_sample(18'd9000);
		send_sample(18'd9000);
		send_sample(18'd200);

		while (sent < RANDOM_ITEMS) begin
			pick_band(hmax, hmin);
			pick_band(lmax, lmin);
			apply_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 9) != 0), hmax, hmin, lmax, lmin);
			pct_sel = $urandom_range(0, 2);
			send_gap_pct = (pct_sel == 0) ? 0 : (pct_sel == 1) ? 10 : 40;
			pct_sel = $urandom_range(0, 2);
			stall_pct = (pct_sel == 0) ? 0 : (pct_sel == 1) ? 2 : 8;
			items = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 6) : $urandom_range(20, 70);
			run = 0;
			kind = 0;
			repeat (items) begin
				if (run == 0) begin
					r = $urandom_range(0, 99);
					kind = (r < 15) ? 0 : (r < 30) ? 1 : (r < 55) ? 2 : (r < 72) ? 3 :
						(r < 84) ? 4 : (r < 90) ? 5 : 6;
					run = $urandom_range(1, 10);
				end
				run--;
				if (sent >= RANDOM_ITEMS - CALM_ITEMS)
					calm = 1'b1;
				if (!calm && $urandom_range(0, 79) == 0)
					wait_drained();
				send_sample(pick_sample(kind));
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d sample beats under %0d register settings, both voltage levels and all",
			sent, settings_used);
		$display("sensitivities; %0d result beats checked, %0d of them with the touch alarm raised",
			chk.checked, chk.alarms_seen);
		if (chk.mismatches == 0)
			$display("** trimmed_mean_band_alarm: PASSED **");
		else
			$display("** trimmed_mean_band_alarm: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tmba_pkg.sv
rtl/core/tmba_cell.sv
rtl/core/tmba_divider.sv
rtl/core/trimmed_mean_band_alarm.sv
verif/tb_trimmed_mean_band_alarm.sv
